// ===== hw/rtl/lorc_pkg.sv =====
package lorc_pkg;

    localparam int ENTRIES = 8;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KEY_W   = 32;
    localparam int REG_W   = 5;
    localparam int STAMP_W = 32;
    localparam int CNT_W   = 32;

    typedef enum logic [1:0] {
        FN_LOOKUP     = 2'd0,
        FN_RECORD     = 2'd1,
        FN_INVALIDATE = 2'd2,
        FN_CLEAR      = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        func_t                    func;
        logic signed [KEY_W-1:0]  offset;
        logic [REG_W-1:0]         reg_num;
    } req_t;

    typedef struct packed {
        logic                     hit;
        logic [REG_W-1:0]         found_reg;
        logic [CNT_W-1:0]         hit_total;
    } rsp_t;

endpackage

// ===== hw/rtl/lru_offset_register_cache_unit.sv =====
// Fully associative LRU cache that maps a signed 32-bit offset key to a 5-bit
// register number. Issue a transaction by raising start while busy is low; the
// request is taken at that clock edge. Each transaction yields exactly one
// result, shown on rsp for one cycle while done is high; the receiver cannot
// stall it, so capture it on that cycle. A transaction is entered from idle;
// the scan state then walks the entries in order, one entry per cycle, while a
// single shared key comparator and age subtractor examine each entry in turn;
// the finish state then updates the selected entry and registers the result.
// done rises as busy falls, and a new start is taken in that same
// cycle. The cache_enable register (cfg_we / cfg_wdata, reset 1) may only be
// written while no transaction is in flight; with it at 0, lookups miss and
// records are dropped, while invalidate and clear still act. Stamps and the
// hit counter wrap at 32 bits; on an eviction the entry with the largest age
// (current stamp minus entry stamp) is replaced, lowest index on ties, and an
// empty entry is always taken first.
module lru_offset_register_cache_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  lorc_pkg::req_t      req,
    output logic                done,
    output lorc_pkg::rsp_t      rsp,
    input  logic                cfg_we,
    input  logic                cfg_wdata
);

    localparam logic [lorc_pkg::IDX_W-1:0] LAST_IDX =
        lorc_pkg::IDX_W'(lorc_pkg::ENTRIES - 1);

    // Entry storage: valid bits cleared by reset, payload undefined until written
    logic                          valid_reg [lorc_pkg::ENTRIES];
    logic [lorc_pkg::KEY_W-1:0]    key_reg   [lorc_pkg::ENTRIES];
    logic [lorc_pkg::REG_W-1:0]    preg_reg  [lorc_pkg::ENTRIES];
    logic [lorc_pkg::STAMP_W-1:0]  stamp_reg [lorc_pkg::ENTRIES];

    lorc_pkg::state_t              state_reg, state_next;
    lorc_pkg::req_t                op_reg;
    logic [lorc_pkg::IDX_W-1:0]    idx_reg;
    logic [lorc_pkg::STAMP_W-1:0]  access_reg;
    logic [lorc_pkg::CNT_W-1:0]    hits_reg, hits_next;
    logic                          enable_reg;

    // Scan trackers
    logic                          match_reg;
    logic [lorc_pkg::IDX_W-1:0]    match_idx_reg;
    logic [lorc_pkg::REG_W-1:0]    match_preg_reg;
    logic                          empty_reg;
    logic [lorc_pkg::IDX_W-1:0]    empty_idx_reg;
    logic                          best_set_reg;
    logic [lorc_pkg::STAMP_W-1:0]  best_age_reg;
    logic [lorc_pkg::IDX_W-1:0]    best_idx_reg;

    logic                          done_reg;
    lorc_pkg::rsp_t                rsp_reg, rsp_next;

    // FSM decode
    logic accept;
    logic scanning;
    logic finishing;

    // Shared compare unit, fed from the entry under the scan index
    logic                          cur_valid;
    logic                          key_eq;
    logic                          preg_eq;
    logic [lorc_pkg::STAMP_W-1:0]  cur_age;
    logic                          age_gt;

    // Finish-stage decode
    logic                          do_lookup;
    logic                          do_record;
    logic                          look_hit;
    logic [lorc_pkg::IDX_W-1:0]    wr_idx;

    assign cur_valid = valid_reg[idx_reg];
    assign key_eq    = (key_reg[idx_reg] == op_reg.offset);
    assign preg_eq   = (preg_reg[idx_reg] == op_reg.reg_num);
    assign cur_age   = access_reg - stamp_reg[idx_reg];
    assign age_gt    = (cur_age > best_age_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lorc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = lorc_pkg::ST_SCAN;
                end
            end
            lorc_pkg::ST_SCAN:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = lorc_pkg::ST_FINISH;
                end
            end
            lorc_pkg::ST_FINISH:
            begin
                state_next = lorc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lorc_pkg::ST_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        busy      = 1'b1;
        scanning  = 1'b0;
        finishing = 1'b0;
        case (state_reg)
            lorc_pkg::ST_IDLE:   busy      = 1'b0;
            lorc_pkg::ST_SCAN:   scanning  = 1'b1;
            lorc_pkg::ST_FINISH: finishing = 1'b1;
            default:             busy      = 1'b1;
        endcase
    end

    assign accept = start && !busy;

    // Pick the target entry and build the result
    always_comb
    begin
        do_lookup = enable_reg && (op_reg.func == lorc_pkg::FN_LOOKUP);
        do_record = enable_reg && (op_reg.func == lorc_pkg::FN_RECORD);
        look_hit  = do_lookup && match_reg;

        if (match_reg)
        begin
            wr_idx = match_idx_reg;
        end
        else if (empty_reg)
        begin
            wr_idx = empty_idx_reg;
        end
        else
        begin
            wr_idx = best_idx_reg;
        end

        hits_next          = hits_reg + lorc_pkg::CNT_W'(look_hit);
        rsp_next.hit       = look_hit;
        rsp_next.found_reg = look_hit ? match_preg_reg : '0;
        rsp_next.hit_total = hits_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lorc_pkg::ST_IDLE;
            access_reg <= '0;
            hits_reg   <= '0;
            enable_reg <= 1'b1;
            done_reg   <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= finishing;
            if (cfg_we)
            begin
                enable_reg <= cfg_wdata;
            end
            if (accept)
            begin
                idx_reg <= '0;
                // Bump the stamp for enabled lookups and records only
                if (enable_reg && ((req.func == lorc_pkg::FN_LOOKUP) ||
                                   (req.func == lorc_pkg::FN_RECORD)))
                begin
                    access_reg <= access_reg + lorc_pkg::STAMP_W'(1);
                end
            end
            else if (scanning && (idx_reg != LAST_IDX))
            begin
                idx_reg <= idx_reg + lorc_pkg::IDX_W'(1);
            end
            if (finishing)
            begin
                hits_reg <= hits_next;
            end
        end
    end

    // Valid bits: invalidate drops during the scan, record sets, clear drops all
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lorc_pkg::ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (scanning && (op_reg.func == lorc_pkg::FN_INVALIDATE) &&
                 cur_valid && preg_eq)
        begin
            valid_reg[idx_reg] <= 1'b0;
        end
        else if (finishing && (op_reg.func == lorc_pkg::FN_CLEAR))
        begin
            for (int i = 0; i < lorc_pkg::ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (finishing && do_record)
        begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    // Entry payload
    always_ff @(posedge clk)
    begin
        if (finishing && do_record)
        begin
            key_reg[wr_idx]   <= op_reg.offset;
            preg_reg[wr_idx]  <= op_reg.reg_num;
            stamp_reg[wr_idx] <= access_reg;
        end
        else if (finishing && look_hit)
        begin
            stamp_reg[match_idx_reg] <= access_reg;
        end
    end

    // Request hold and scan trackers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= req;
            match_reg    <= 1'b0;
            empty_reg    <= 1'b0;
            best_set_reg <= 1'b0;
        end
        else if (scanning)
        begin
            if (cur_valid && key_eq && !match_reg)
            begin
                match_reg      <= 1'b1;
                match_idx_reg  <= idx_reg;
                match_preg_reg <= preg_reg[idx_reg];
            end
            if (!cur_valid && !empty_reg)
            begin
                empty_reg     <= 1'b1;
                empty_idx_reg <= idx_reg;
            end
            if (cur_valid && (!best_set_reg || age_gt))
            begin
                best_set_reg <= 1'b1;
                best_age_reg <= cur_age;
                best_idx_reg <= idx_reg;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (finishing)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // The strobe follows the finish cycle only
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == lorc_pkg::ST_FINISH))
        else $error("done without a finish cycle");

    // Reported hit total matches the live counter
    a_total_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.hit_total == hits_reg))
        else $error("hit_total out of step with counter");

    // A miss reports register zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.hit) |-> (rsp.found_reg == '0))
        else $error("found_reg nonzero on a miss");

    // The scan ends at the last entry and moves to finish
    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (scanning && (idx_reg == LAST_IDX)) |=> (state_reg == lorc_pkg::ST_FINISH))
        else $error("scan did not end at the last entry");

    // An accepted transaction makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("not busy after accept");

endmodule
